FILE: hw/rtl/ket_pkg.sv
// shared types and constants for the key event trigger table
// no dependencies; imported by the controller, datapath and top level
package ket_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int SLOT_W        = 5;
    localparam int COUNT_W       = 16;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 8;

    localparam logic [COUNT_W-1:0] COUNT_WRAP = 16'hFFFF;

    // input item as packed in s_tdata, last member in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] repeat_period;
        logic               fire_on_release;
        logic               fire_on_press;
        logic               pressed;
        logic [SLOT_W-1:0]  slot;
    } in_item_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } ket_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } ket_status_t;

endpackage

FILE: hw/rtl/ket_ctrl.sv
// controller state machine: capture, table read, update and commit
// depends on ket_pkg
module ket_ctrl
    import ket_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ket_status_t status,
    output ket_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (!status.out_blocked)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/ket_datapath.sv
// datapath: input register, hold count table with valid bits, update logic
// and output register; depends on ket_pkg
module ket_datapath
    import ket_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // slot, pressed, fire_on_press, fire_on_release, repeat_period
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // fire
    input  ket_cmd_t              cmd,
    output ket_status_t           status
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = ($clog2(SLOTS + 1) > SLOT_W) ? $clog2(SLOTS + 1) : SLOT_W;
    localparam int EXT_W  = CNT_W + 1;

    in_item_t           in_reg;
    logic [COUNT_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               rd_valid_reg;
    logic               out_valid_reg;
    logic               out_fire_reg;

    logic [EXT_W-1:0]   slot_ext;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] cnt_next;
    logic               fire_next;

    assign slot_ext = {{(EXT_W - SLOT_W){1'b0}}, in_reg.slot};
    assign idx      = slot_ext[IDX_W-1:0];
    assign in_range = slot_ext < EXT_W'(SLOTS);
    assign cnt      = rd_valid_reg ? rd_data_reg : '0;
    assign cnt_inc  = cnt + COUNT_W'(1);

    always_comb
    begin
        cnt_next  = '0;
        fire_next = 1'b0;
        if (in_reg.pressed)
        begin
            if (in_reg.fire_on_press && (cnt == '0))
            begin
                cnt_next  = COUNT_W'(1);
                fire_next = 1'b1;
            end
            else if ((in_reg.repeat_period != '0) && (cnt_inc == in_reg.repeat_period))
            begin
                cnt_next  = COUNT_W'(1);
                fire_next = 1'b1;
            end
            else if (cnt_inc == COUNT_WRAP)
            begin
                cnt_next = COUNT_W'(1);
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
        else
        begin
            fire_next = in_reg.fire_on_release && (cnt != '0);
        end
    end

    // input capture and table access
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_item_t'(s_tdata);
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[idx];
        end
        if (cmd.commit && in_range)
        begin
            mem[idx] <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.read)
            begin
                rd_valid_reg <= valid_reg[idx];
            end
            if (cmd.commit && in_range)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_fire_reg <= fire_next && in_range;
        end
    end

    assign status.out_blocked = out_valid_reg && !m_tready;
    assign m_tvalid           = out_valid_reg;
    assign m_tdata            = {{(OUT_DATA_W - 1){1'b0}}, out_fire_reg};

endmodule

FILE: hw/rtl/key_event_trigger_table.sv
// top level of the key event trigger table
// depends on ket_pkg, ket_ctrl and ket_datapath
//
// Each key event reads its slot's 16-bit hold count, updates it and returns one
// fire flag. An item goes from acceptance to commit through capture, a registered
// table read, then update and write back, and no new item is taken before the
// last commits; the result waits in an output register, and a commit
// waits only while that register is still full and not being taken. Slots at or
// beyond SLOTS leave the table alone and return no fire. The table comes out of
// reset all zero at once through one valid bit per slot, with no clearing pass.
module key_event_trigger_table
    import ket_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // slot, pressed, fire_on_press, fire_on_release, repeat_period
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // fire
);

    ket_cmd_t    cmd;
    ket_status_t status;

    ket_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ket_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

    // no new transfer while an item is being read and updated
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input accepted while an item is in flight");

    // commit never overwrites a result that is not taken
    a_commit_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("commit over a pending result");

    // every commit shows a result in the next cycle
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("commit without a result");

    // padding bits of the result stay zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:1] == '0))
        else $error("nonzero padding in m_tdata");

endmodule
